// ===== hw/rtl/ibba_pkg.sv =====
// Shared types and constants for the inode/block bitmap allocator.
package ibba_pkg;

    localparam int DEF_MAX_INODES = 256;
    localparam int DEF_MAX_BLOCKS = 1024;

    localparam int WORD_W      = 32;
    localparam int WORD_LG     = 5;
    localparam int CNT_W       = 17;   // holds any map depth up to 65536
    localparam int IDX_W       = 16;   // entry index, depth at most 65536
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int ICNT_W      = 9;
    localparam int BCNT_W      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INODE_COUNT = 3'd0,
        CFG_BLOCK_COUNT = 3'd1,
        CFG_INODE_BASE  = 3'd2,
        CFG_INODE_BYTES = 3'd3,
        CFG_BLOCK_BASE  = 3'd4,
        CFG_BLOCK_BYTES = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_ALLOC_INODE = 2'd0,
        KIND_ALLOC_BLOCK = 2'd1,
        KIND_FREE_INODE  = 2'd2,
        KIND_FREE_BLOCK  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_MUL,
        S_FIN,
        S_DIV,
        S_RCHK,
        S_RMW
    } t_state;

endpackage

// ===== hw/rtl/inode_block_bitmap_allocator_top.sv =====
// First-fit inode/block bitmap allocator: two word-wide used maps, search and release sequencer.
//
// The block owns two used/free bitmaps, one bit per inode and one per data block, kept
// in two 32-bit-wide memories. After reset a clearing pass zeroes both maps, one word per
// cycle, over ceil(max(MAX_INODES, MAX_BLOCKS) / 32) words; s_axis_tready stays low
// meanwhile, configuration writes are taken as ever. One request word is worked on at a
// time. An allocate scans its map one 32-bit word at a time (memory read in S_RD, then a
// priority pick of the lowest free bit under the count mask in S_CHK), then forms
// index * size in the 16x16 multiplier (S_MUL) and adds the base in S_FIN. A release
// runs a restoring divider one quotient bit per cycle for a 32-bit quotient, checks the
// index, then does a read-modify-write of one map word; it goes straight to a range
// result when the address is below the base or the entry size is zero. A finished
// result sits in an output register, so the next request is accepted while it waits.
// Configuration writes must only happen while no request is in flight.
module inode_block_bitmap_allocator_top #(
    parameter int MAX_INODES = ibba_pkg::DEF_MAX_INODES,
    parameter int MAX_BLOCKS = ibba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [ibba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ibba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ibba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [31:0] release_address
    input  logic [ibba_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // [1:0] kind
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ibba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // [31:0] granted_address,
                                                              // [33:32] status, [39:34] zero
);
    import ibba_pkg::*;

    // map geometry
    localparam int NWI    = (MAX_INODES + WORD_W - 1) / WORD_W;
    localparam int NWB    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AWI    = (NWI > 1) ? $clog2(NWI) : 1;
    localparam int AWB    = (NWB > 1) ? $clog2(NWB) : 1;
    localparam int NW_MAX = (NWI > NWB) ? NWI : NWB;
    localparam int WCNT_W = $clog2(NW_MAX + 1);
    localparam int REM_W  = CNT_W + 1;

    // ---------------- configuration registers ----------------
    logic [ICNT_W-1:0] r_inode_count;
    logic [BCNT_W-1:0] r_block_count;
    logic [ADDR_W-1:0] r_inode_base;
    logic [SIZE_W-1:0] r_inode_bytes;
    logic [ADDR_W-1:0] r_block_base;
    logic [SIZE_W-1:0] r_block_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_count <= ICNT_W'(256);
            r_block_count <= BCNT_W'(1024);
            r_inode_base  <= '0;
            r_inode_bytes <= SIZE_W'(128);
            r_block_base  <= '0;
            r_block_bytes <= SIZE_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INODE_COUNT: r_inode_count <= i_cfg_data[ICNT_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCNT_W-1:0];
                CFG_INODE_BASE:  r_inode_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_INODE_BYTES: r_inode_bytes <= i_cfg_data[SIZE_W-1:0];
                CFG_BLOCK_BASE:  r_block_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[SIZE_W-1:0];
                default: ;   // unknown index: ignored
            endcase
        end
    end

    // ---------------- sequencer registers ----------------
    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    t_status            r_stat, n_stat;
    logic [WCNT_W-1:0]  r_word, n_word;     // word pointer for clear and search
    logic [IDX_W-1:0]   r_idx, n_idx;       // granted entry index
    logic [ADDR_W-1:0]  r_prod, n_prod;     // index * size
    logic [ADDR_W-1:0]  r_q, n_q;           // dividend shifting out, quotient shifting in
    logic [SIZE_W-1:0]  r_rem, n_rem;       // partial remainder
    logic [WORD_LG-1:0] r_step, n_step;     // divide step count
    logic               r_m_tvalid, n_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    // ---------------- map memories ----------------
    logic [WORD_W-1:0] r_imap [NWI];
    logic [WORD_W-1:0] r_bmap [NWB];
    logic [WORD_W-1:0] r_rd_i, r_rd_b;
    logic [AWI-1:0]    w_addr_i;
    logic [AWB-1:0]    w_addr_b;
    logic              w_we_i, w_we_b;
    logic [WORD_W-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        r_rd_i <= r_imap[w_addr_i];
        if (w_we_i) begin
            r_imap[w_addr_i] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_b <= r_bmap[w_addr_b];
        if (w_we_b) begin
            r_bmap[w_addr_b] <= w_wdata;
        end
    end

    // ---------------- datapath helpers ----------------
    logic              w_in_acc;
    logic              w_sel_blk;      // 1: block map, 0: inode map
    t_kind             w_in_kind;
    logic [ADDR_W-1:0] w_base;
    logic [SIZE_W-1:0] w_size;
    logic [CNT_W-1:0]  w_eff_i, w_eff_b, w_eff;
    logic [REM_W-1:0]  w_rem_ent;      // entries left from current word on
    logic              w_rem_pos;
    logic [WORD_W-1:0] w_mask, w_rd, w_free, w_bit_sel;
    logic [WORD_LG-1:0] w_pos;
    logic [WORD_LG-1:0] w_rel_bit;
    logic [CNT_W:0]    w_trial;
    logic              w_ge;
    logic              w_out_free;
    logic              w_idx_ok;

    assign w_in_kind = t_kind'(s_axis_tuser);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_sel_blk = (r_state == S_IDLE) ? w_in_kind[0] : r_kind[0];
    assign w_base    = w_sel_blk ? r_block_base : r_inode_base;
    assign w_size    = w_sel_blk ? r_block_bytes : r_inode_bytes;

    // effective count = min(count, map depth)
    assign w_eff_i = (CNT_W'(r_inode_count) < CNT_W'(MAX_INODES)) ?
                     CNT_W'(r_inode_count) : CNT_W'(MAX_INODES);
    assign w_eff_b = (CNT_W'(r_block_count) < CNT_W'(MAX_BLOCKS)) ?
                     CNT_W'(r_block_count) : CNT_W'(MAX_BLOCKS);
    assign w_eff   = w_sel_blk ? w_eff_b : w_eff_i;

    // count mask for the word being searched
    assign w_rem_ent = {1'b0, w_eff} - REM_W'({r_word, {WORD_LG{1'b0}}});
    assign w_rem_pos = !w_rem_ent[REM_W-1] && (w_rem_ent != '0);
    assign w_mask    = (w_rem_ent >= REM_W'(WORD_W)) ? {WORD_W{1'b1}} :
                       ~({WORD_W{1'b1}} << w_rem_ent[WORD_LG-1:0]);
    assign w_rd      = w_sel_blk ? r_rd_b : r_rd_i;
    assign w_free    = ~w_rd & w_mask;

    // lowest free bit
    always_comb begin
        w_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_pos = WORD_LG'(b);
            end
        end
    end

    assign w_rel_bit = r_q[WORD_LG-1:0];
    assign w_bit_sel = {{(WORD_W-1){1'b0}}, 1'b1}
                       << ((r_state == S_RMW) ? w_rel_bit : w_pos);

    // restoring divide step
    assign w_trial = {1'b0, r_rem, r_q[ADDR_W-1]};
    assign w_ge    = w_trial >= (CNT_W+1)'(w_size);

    // quotient must fall below the effective count
    assign w_idx_ok = (r_q[ADDR_W-1:CNT_W] == '0) && (r_q[CNT_W-1:0] < w_eff);

    assign w_out_free = !r_m_tvalid || m_axis_tready;

    // ---------------- next state and outputs ----------------
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_stat     = r_stat;
        n_word     = r_word;
        n_idx      = r_idx;
        n_prod     = r_prod;
        n_q        = r_q;
        n_rem      = r_rem;
        n_step     = r_step;
        n_m_tvalid = (r_m_tvalid && !m_axis_tready);
        n_m_tdata  = r_m_tdata;
        s_axis_tready = 1'b0;
        w_we_i     = 1'b0;
        w_we_b     = 1'b0;
        w_wdata    = '0;
        w_addr_i   = r_word[AWI-1:0];
        w_addr_b   = r_word[AWB-1:0];

        case (r_state)
            S_CLEAR: begin
                w_we_i = (r_word < WCNT_W'(NWI));
                w_we_b = (r_word < WCNT_W'(NWB));
                if (r_word == WCNT_W'(NW_MAX - 1)) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end

            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_acc) begin
                    n_kind = w_in_kind;
                    n_word = '0;
                    n_stat = STAT_DONE;
                    if (!w_in_kind[1]) begin
                        n_state = S_RD;
                    end else if (w_size == '0 || s_axis_tdata < w_base) begin
                        n_stat  = STAT_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_q     = s_axis_tdata - w_base;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end

            // present word address, or stop when past the count
            S_RD: begin
                if (w_rem_pos) begin
                    n_state = S_CHK;
                end else begin
                    n_stat  = STAT_FULL;
                    n_state = S_FIN;
                end
            end

            S_CHK: begin
                if (w_free != '0) begin
                    w_wdata = w_rd | w_bit_sel;
                    w_we_i  = !r_kind[0];
                    w_we_b  = r_kind[0];
                    n_idx   = IDX_W'({r_word, w_pos});
                    n_state = S_MUL;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_RD;
                end
            end

            S_MUL: begin
                n_prod  = ADDR_W'(r_idx * w_size);
                n_state = S_FIN;
            end

            S_FIN: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = '0;
                    n_m_tdata[ADDR_W+1:ADDR_W] = r_stat;
                    if (r_stat == STAT_DONE && !r_kind[1]) begin
                        n_m_tdata[ADDR_W-1:0] = w_base + r_prod;
                    end
                    n_state = S_IDLE;
                end
            end

            S_DIV: begin
                n_q    = {r_q[ADDR_W-2:0], w_ge};
                n_rem  = w_ge ? SIZE_W'(w_trial - (CNT_W+1)'(w_size)) : w_trial[SIZE_W-1:0];
                n_step = r_step + 1'b1;
                if (r_step == {WORD_LG{1'b1}}) begin
                    n_state = S_RCHK;
                end
            end

            S_RCHK: begin
                w_addr_i = r_q[WORD_LG +: AWI];
                w_addr_b = r_q[WORD_LG +: AWB];
                if (w_idx_ok) begin
                    n_state = S_RMW;
                end else begin
                    n_stat  = STAT_RANGE;
                    n_state = S_FIN;
                end
            end

            S_RMW: begin
                w_addr_i = r_q[WORD_LG +: AWI];
                w_addr_b = r_q[WORD_LG +: AWB];
                w_wdata  = w_rd & ~w_bit_sel;
                w_we_i   = !r_kind[0];
                w_we_b   = r_kind[0];
                n_stat   = STAT_DONE;
                n_state  = S_FIN;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_word     <= '0;
            r_step     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_word     <= n_word;
            r_step     <= n_step;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_stat    <= n_stat;
        r_idx     <= n_idx;
        r_prod    <= n_prod;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_m_tdata <= n_m_tdata;
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // ---------------- assertions ----------------
    // an allocation never reports an out-of-range release
    a_alloc_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free && !r_kind[1])
        |=> (m_axis_tdata[ADDR_W+1:ADDR_W] != STAT_RANGE))
        else $error("allocation returned range status");

    // the divider advances one step per cycle while dividing
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_step == $past(r_step) + 1'b1))
        else $error("divider step count slipped");

    // map words are written only by the clear pass, a grant, or a release
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we_i || w_we_b)
        |-> (r_state == S_CLEAR || r_state == S_CHK || r_state == S_RMW))
        else $error("unexpected map write");

    // no request is taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during map clear");

endmodule
